@@ design/msfs_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the multi-sensor frame synchronizer.
// Status codes, register indexes, reset values and field widths; no dependencies.
package msfs_pkg;

    // Default number of sensor slots
    localparam int NUM_SOURCES_DEF = 8;

    // Field widths
    localparam int STAMP_W   = 32;
    localparam int SRC_W     = 3;
    localparam int CFG_CNT_W = 4;
    localparam int MASK_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;

    // Packed channel widths (rounded up to whole bytes)
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 56;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Result status codes
    localparam status_t ST_NONE       = 3'd0;
    localparam status_t ST_DROPPED    = 3'd1;
    localparam status_t ST_WAITING    = 3'd2;
    localparam status_t ST_MERGED     = 3'd3;
    localparam status_t ST_TO_MERGED  = 3'd4;
    localparam status_t ST_TO_CLEARED = 3'd5;

    // Action codes
    localparam logic ACT_ARRIVAL = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // Configuration register indexes
    localparam cfg_idx_t REG_MAX_SKEW    = 2'd0;
    localparam cfg_idx_t REG_STALE_TIME  = 2'd1;
    localparam cfg_idx_t REG_MIN_SOURCES = 2'd2;
    localparam cfg_idx_t REG_EXP_SOURCES = 2'd3;

    // Configuration reset values
    localparam logic [STAMP_W-1:0]   MAX_SKEW_RST    = 32'd1000000;
    localparam logic [STAMP_W-1:0]   STALE_TIME_RST  = 32'd500000;
    localparam logic [CFG_CNT_W-1:0] MIN_SOURCES_RST = 4'd2;
    localparam logic [CFG_CNT_W-1:0] EXP_SOURCES_RST = 4'd2;

endpackage

@@ design/multi_sensor_frame_sync.sv @@
`timescale 1ns / 1ps
// Top level of the multi-sensor frame synchronizer: slot control, scans and output register.
// Depends on msfs_pkg and msfs_ram.
//
// One transaction in, one result out. A frame arrival with frame_ok low or a source_id at or
// beyond NUM_SOURCES is reported as dropped without a scan, once the output register is free.
// Every other arrival writes its capture stamp into the slot RAM and then scans all slots
// through the RAM's single read port: one pass for the full count and newest stamp, and, when
// enough slots are full, a second pass over all slots for the skew checks. A timeout tick
// takes the first pass only. A new transaction is taken as soon as the result is placed in the
// output register, even while it still waits for m_tready. The slot stamps need no clearing
// after reset; per-slot valid flags gate them.
module multi_sensor_frame_sync
    import msfs_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STAMP_W-1:0]   cfg_wdata,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [2:0] source_id, [3] frame_ok, [35:4] capture_stamp, [67:36] now_stamp
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] action
    input  logic                 s_tuser,
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] merge_mask, [39:8] reference_stamp, [47:40] rejected_mask, [51:48] sources_merged
    output logic [M_TDATA_W-1:0] m_tdata,
    // [2:0] status
    output logic [STATUS_W-1:0]  m_tuser
);

    localparam int SLOT_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int CNT_W  = $clog2(NUM_SOURCES + 1);
    localparam int CMP_W  = CNT_W + CFG_CNT_W;

    // Controller states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN1 = 2'd1;
    localparam logic [1:0] S_SCAN2 = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    // Input field unpack
    logic               in_action;
    logic [SRC_W-1:0]   in_src;
    logic               in_ok;
    logic [STAMP_W-1:0] in_cap;
    logic [STAMP_W-1:0] in_now;

    assign in_action = s_tuser;
    assign in_src    = s_tdata[2:0];
    assign in_ok     = s_tdata[3];
    assign in_cap    = s_tdata[35:4];
    assign in_now    = s_tdata[67:36];

    // Configuration registers
    logic [STAMP_W-1:0]   max_skew_reg;
    logic [STAMP_W-1:0]   stale_time_reg;
    logic [CFG_CNT_W-1:0] min_src_reg;
    logic [CFG_CNT_W-1:0] exp_src_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_skew_reg   <= MAX_SKEW_RST;
            stale_time_reg <= STALE_TIME_RST;
            min_src_reg    <= MIN_SOURCES_RST;
            exp_src_reg    <= EXP_SOURCES_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_SKEW:    max_skew_reg   <= cfg_wdata;
                REG_STALE_TIME:  stale_time_reg <= cfg_wdata;
                REG_MIN_SOURCES: min_src_reg    <= cfg_wdata[CFG_CNT_W-1:0];
                REG_EXP_SOURCES: exp_src_reg    <= cfg_wdata[CFG_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Control and working registers
    logic [1:0]             state_reg, state_next;
    logic [NUM_SOURCES-1:0] slot_valid_reg, slot_valid_next;
    logic [STAMP_W-1:0]     last_arrival_reg, last_arrival_next;
    logic                   action_reg, action_next;
    logic                   stale_reg, stale_next;
    logic [STAMP_W-1:0]     now_reg, now_next;
    logic [SLOT_W:0]        issue_reg, issue_next;
    logic                   pend_reg, pend_next;
    logic [SLOT_W-1:0]      pidx_reg, pidx_next;
    logic [CNT_W-1:0]       full_cnt_reg, full_cnt_next;
    logic [NUM_SOURCES-1:0] full_mask_reg, full_mask_next;
    logic [STAMP_W-1:0]     ref_reg, ref_next;
    logic [CNT_W-1:0]       vcnt_reg, vcnt_next;
    logic [NUM_SOURCES-1:0] vmask_reg, vmask_next;
    logic [NUM_SOURCES-1:0] rmask_reg, rmask_next;
    // Pending result
    status_t                res_status_reg, res_status_next;
    logic [NUM_SOURCES-1:0] res_mmask_reg, res_mmask_next;
    logic [STAMP_W-1:0]     res_ref_reg, res_ref_next;
    logic [NUM_SOURCES-1:0] res_rmask_reg, res_rmask_next;
    logic [CNT_W-1:0]       res_cnt_reg, res_cnt_next;
    // Output register
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;
    status_t                m_user_reg, m_user_next;

    // RAM ports
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic               ram_re;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [STAMP_W-1:0] ram_rdata;

    msfs_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (NUM_SOURCES)
    ) u_stamp_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (in_cap),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    logic               s_accept;
    logic               src_in_range;
    logic [SLOT_W-1:0]  src_idx;
    logic               scan_done;
    logic               slot_hit;
    logic [STAMP_W-1:0] skew;
    logic [CMP_W-1:0]   full_cmp, vcnt_cmp, min_cmp, exp_cmp;
    logic               merge_ok;

    // Output packing helpers
    logic [NUM_SOURCES+MASK_W-1:0]  mmask_pad, rmask_pad;
    logic [CNT_W+CFG_CNT_W-1:0]     cnt_pad;

    assign s_tready     = (state_reg == S_IDLE);
    assign s_accept     = s_tvalid && s_tready;
    assign src_in_range = (32'(in_src) < NUM_SOURCES);
    assign src_idx      = SLOT_W'(in_src);
    assign scan_done    = (issue_reg == (SLOT_W + 1)'(NUM_SOURCES)) && !pend_reg;
    assign slot_hit     = pend_reg && slot_valid_reg[pidx_reg];
    assign skew         = ref_reg - ram_rdata;
    assign full_cmp     = CMP_W'(full_cnt_reg);
    assign vcnt_cmp     = CMP_W'(vcnt_reg);
    assign min_cmp      = CMP_W'(min_src_reg);
    assign exp_cmp      = CMP_W'(exp_src_reg);
    assign merge_ok     = (vcnt_cmp >= min_cmp) && (full_cmp == exp_cmp);

    assign mmask_pad = {{MASK_W{1'b0}}, res_mmask_reg};
    assign rmask_pad = {{MASK_W{1'b0}}, res_rmask_reg};
    assign cnt_pad   = {{CFG_CNT_W{1'b0}}, res_cnt_reg};

    // Store arrivals and sweep the slot RAM
    assign ram_we    = s_accept && (in_action == ACT_ARRIVAL) && in_ok && src_in_range;
    assign ram_waddr = src_idx;
    assign ram_re    = ((state_reg == S_SCAN1) || (state_reg == S_SCAN2)) &&
                       (issue_reg < (SLOT_W + 1)'(NUM_SOURCES));
    assign ram_raddr = issue_reg[SLOT_W-1:0];

    always_comb begin
        state_next        = state_reg;
        slot_valid_next   = slot_valid_reg;
        last_arrival_next = last_arrival_reg;
        action_next       = action_reg;
        stale_next        = stale_reg;
        now_next          = now_reg;
        issue_next        = issue_reg;
        pend_next         = 1'b0;
        pidx_next         = pidx_reg;
        full_cnt_next     = full_cnt_reg;
        full_mask_next    = full_mask_reg;
        ref_next          = ref_reg;
        vcnt_next         = vcnt_reg;
        vmask_next        = vmask_reg;
        rmask_next        = rmask_reg;
        res_status_next   = res_status_reg;
        res_mmask_next    = res_mmask_reg;
        res_ref_next      = res_ref_reg;
        res_rmask_next    = res_rmask_reg;
        res_cnt_next      = res_cnt_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;
        m_user_next       = m_user_reg;

        // Retire a delivered result
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // Advance the read sweep
        if (ram_re) begin
            issue_next = issue_reg + 1'b1;
            pend_next  = 1'b1;
            pidx_next  = issue_reg[SLOT_W-1:0];
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    action_next    = in_action;
                    now_next       = in_now;
                    stale_next     = (in_now - last_arrival_reg) > stale_time_reg;
                    issue_next     = '0;
                    full_cnt_next  = '0;
                    full_mask_next = '0;
                    ref_next       = '0;
                    if (in_action == ACT_TICK) begin
                        state_next = S_SCAN1;
                    end else if (in_ok && src_in_range) begin
                        slot_valid_next[src_idx] = 1'b1;
                        last_arrival_next        = in_now;
                        state_next               = S_SCAN1;
                    end else begin
                        res_status_next = ST_DROPPED;
                        res_mmask_next  = '0;
                        res_ref_next    = '0;
                        res_rmask_next  = '0;
                        res_cnt_next    = '0;
                        state_next      = S_OUT;
                    end
                end
            end

            S_SCAN1: begin
                // Count full slots and track the newest stamp
                if (slot_hit) begin
                    full_cnt_next            = full_cnt_reg + 1'b1;
                    full_mask_next[pidx_reg] = 1'b1;
                    if (ram_rdata > ref_reg) begin
                        ref_next = ram_rdata;
                    end
                end
                if (scan_done) begin
                    res_status_next = ST_WAITING;
                    res_mmask_next  = '0;
                    res_ref_next    = '0;
                    res_rmask_next  = '0;
                    res_cnt_next    = '0;
                    state_next      = S_OUT;
                    if (action_reg == ACT_ARRIVAL) begin
                        if (full_cmp >= min_cmp) begin
                            issue_next = '0;
                            vcnt_next  = '0;
                            vmask_next = '0;
                            rmask_next = '0;
                            state_next = S_SCAN2;
                        end
                    end else if ((full_cnt_reg == '0) || !stale_reg) begin
                        res_status_next = ST_NONE;
                    end else begin
                        if (full_cmp >= min_cmp) begin
                            res_status_next = ST_TO_MERGED;
                            res_mmask_next  = full_mask_reg;
                            res_ref_next    = ref_reg;
                            res_cnt_next    = full_cnt_reg;
                        end else begin
                            res_status_next = ST_TO_CLEARED;
                        end
                        slot_valid_next   = '0;
                        last_arrival_next = now_reg;
                    end
                end
            end

            S_SCAN2: begin
                // Reject slots beyond the allowed skew
                if (slot_hit) begin
                    if (skew > max_skew_reg) begin
                        slot_valid_next[pidx_reg] = 1'b0;
                        rmask_next[pidx_reg]      = 1'b1;
                    end else begin
                        vmask_next[pidx_reg] = 1'b1;
                        vcnt_next            = vcnt_reg + 1'b1;
                    end
                end
                if (scan_done) begin
                    res_ref_next   = ref_reg;
                    res_rmask_next = rmask_reg;
                    state_next     = S_OUT;
                    if (merge_ok) begin
                        res_status_next = ST_MERGED;
                        res_mmask_next  = vmask_reg;
                        res_cnt_next    = vcnt_reg;
                        slot_valid_next = '0;
                    end else begin
                        res_status_next = ST_WAITING;
                        res_mmask_next  = '0;
                        res_cnt_next    = '0;
                    end
                end
            end

            S_OUT: begin
                // Hand the result to the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_status_reg;
                    m_data_next  = {4'b0000, cnt_pad[CFG_CNT_W-1:0],
                                    rmask_pad[MASK_W-1:0], res_ref_reg,
                                    mmask_pad[MASK_W-1:0]};
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            slot_valid_reg   <= '0;
            last_arrival_reg <= '0;
            pend_reg         <= 1'b0;
            issue_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            slot_valid_reg   <= slot_valid_next;
            last_arrival_reg <= last_arrival_next;
            pend_reg         <= pend_next;
            issue_reg        <= issue_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload and scan accumulators
    always_ff @(posedge aclk) begin
        action_reg     <= action_next;
        stale_reg      <= stale_next;
        now_reg        <= now_next;
        pidx_reg       <= pidx_next;
        full_cnt_reg   <= full_cnt_next;
        full_mask_reg  <= full_mask_next;
        ref_reg        <= ref_next;
        vcnt_reg       <= vcnt_next;
        vmask_reg      <= vmask_next;
        rmask_reg      <= rmask_next;
        res_status_reg <= res_status_next;
        res_mmask_reg  <= res_mmask_next;
        res_ref_reg    <= res_ref_next;
        res_rmask_reg  <= res_rmask_next;
        res_cnt_reg    <= res_cnt_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    // A normal merge empties every slot
    a_merge_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN2 && scan_done && merge_ok) |=> (slot_valid_reg == '0))
        else $error("slots not cleared after merge");

    // No source is both merged and rejected
    a_mask_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg[7:0] & m_data_reg[47:40]) == 8'h00))
        else $error("merge and reject masks overlap");

    // A dropped frame reports no other field
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg == ST_DROPPED) |-> (m_data_reg == '0))
        else $error("dropped result carries data");

    // No read is in flight when a new transaction may enter
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_reg)
        else $error("read pending while idle");

    // A tick never touches the slot RAM write port
    a_tick_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_action == ACT_TICK) |-> !ram_we)
        else $error("tick wrote slot RAM");
`endif

endmodule

@@ design/msfs_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module msfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
